// ===== src/scd_pkg.sv =====
package scd_pkg;

   localparam int FUNC_W = 2;

   // operation codes of a request beat; the fourth code is unused
   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_FLUSH = 2'd2
   } func_type;

   // controller to datapath
   typedef struct packed {
      logic accept;      // capture the request beat, restart the scan
      logic lookup;      // tag search step
      logic emit_hit;    // load hit response, touch the slot
      logic sweep;       // clock hand step
      logic emit_miss;   // load miss response, install the new tag
      logic flush_scan;  // flush search step
      logic emit_flush;  // load writeback response, clean the slot
      logic emit_empty;  // load the empty flush response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic lookup_miss;
      logic victim_found;
      logic flush_found;
      logic flush_last;
      logic none_dirty;
      logic out_free;
   } status_type;

endpackage

// ===== src/scd_req_if.sv =====
interface scd_req_if #(
   parameter int SECTOR_BITS = 32
);
   import scd_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FUNC_W-1:0]      func;
   logic [SECTOR_BITS-1:0] sector;

   modport source (output valid, output func, output sector, input ready);
   modport sink   (input valid, input func, input sector, output ready);

endinterface

// ===== src/scd_rsp_if.sv =====
interface scd_rsp_if #(
   parameter int SLOT_W      = 6,
   parameter int SECTOR_BITS = 32
);

   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [SLOT_W-1:0]      slot;
   logic                   fill_needed;
   logic                   writeback_needed;
   logic [SECTOR_BITS-1:0] writeback_sector;
   logic                   last;

   modport source (
      output valid, output hit, output slot, output fill_needed,
      output writeback_needed, output writeback_sector, output last,
      input ready
   );
   modport sink (
      input valid, input hit, input slot, input fill_needed,
      input writeback_needed, input writeback_sector, input last,
      output ready
   );

endinterface

// ===== src/scd_ram.sv =====
module scd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/scd_ctrl.sv =====
module scd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [scd_pkg::FUNC_W-1:0] req_func,
   output logic                       req_ready,
   input  scd_pkg::status_type        status,
   output scd_pkg::cmd_type           cmd
);
   import scd_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LOOKUP = 9'b000000010,
      ST_HIT    = 9'b000000100,
      ST_SWEEP  = 9'b000001000,
      ST_MISS   = 9'b000010000,
      ST_FSCAN  = 9'b000100000,
      ST_FEMIT  = 9'b001000000,
      ST_FEMPTY = 9'b010000000,
      ST_DROP   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_func)
                  FUNC_READ, FUNC_WRITE: begin
                     state_in = ST_LOOKUP;
                  end
                  FUNC_FLUSH: begin
                     state_in = status.none_dirty ? ST_FEMPTY : ST_FSCAN;
                  end
                  default: begin
                     state_in = ST_DROP;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            priority if (status.hit) begin
               state_in = ST_HIT;
            end else if (status.lookup_miss) begin
               state_in = ST_SWEEP;
            end
         end
         ST_HIT: begin
            if (status.out_free) begin
               cmd.emit_hit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.victim_found) begin
               state_in = ST_MISS;
            end
         end
         ST_MISS: begin
            if (status.out_free) begin
               cmd.emit_miss = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FSCAN: begin
            cmd.flush_scan = 1'b1;
            if (status.flush_found) begin
               state_in = ST_FEMIT;
            end
         end
         ST_FEMIT: begin
            if (status.out_free) begin
               cmd.emit_flush = 1'b1;
               state_in       = status.flush_last ? ST_IDLE : ST_FSCAN;
            end
         end
         ST_FEMPTY: begin
            if (status.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_DROP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/scd_dpath.sv =====
module scd_dpath #(
   parameter int SLOTS       = 64,
   parameter int SECTOR_BITS = 32,
   localparam int SLOT_W     = $clog2(SLOTS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [scd_pkg::FUNC_W-1:0] req_func,
   input  logic [SECTOR_BITS-1:0]     req_sector,
   input  scd_pkg::cmd_type           cmd,
   output scd_pkg::status_type        status,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic                       rsp_fill_needed,
   output logic                       rsp_writeback_needed,
   output logic [SECTOR_BITS-1:0]     rsp_writeback_sector,
   output logic                       rsp_last
);
   import scd_pkg::*;

   localparam int CNT_W = SLOT_W + 1;

   // captured request
   logic [FUNC_W-1:0]      func_ff;
   logic [SECTOR_BITS-1:0] sector_ff;

   // per slot state bits
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] dirty_ff, dirty_in;
   logic [SLOTS-1:0] ref_ff, ref_in;
   logic [SLOT_W-1:0] hand_ff, hand_in;

   // scan counter shared by lookup and flush, compare stage of the lookup
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic [SLOT_W-1:0] scan_idx;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_fill_ff, rsp_fill_in;
   logic                   rsp_wb_ff, rsp_wb_in;
   logic [SECTOR_BITS-1:0] rsp_wbsec_ff, rsp_wbsec_in;
   logic                   rsp_last_ff, rsp_last_in;

   // tag memory ports
   logic                   tag_rd_en;
   logic [SLOT_W-1:0]      tag_rd_addr;
   logic [SECTOR_BITS-1:0] tag_rd_data;

   logic             is_write;
   logic             tag_hit;
   logic             issue_ok;
   logic             lookup_issue;
   logic             victim_ok;
   logic             victim_dirty;
   logic             flush_found;
   logic             any_emit;
   logic [SLOTS-1:0] dirty_live;
   logic [SLOTS-1:0] others_live;

   assign scan_idx     = scan_ff[SLOT_W-1:0];
   assign is_write     = (func_ff == FUNC_WRITE);
   assign tag_hit      = cmp_vld_ff && valid_ff[cmp_idx_ff] && (tag_rd_data == sector_ff);
   assign issue_ok     = (scan_ff != CNT_W'(SLOTS));
   assign lookup_issue = cmd.lookup && !tag_hit && issue_ok;
   assign victim_ok    = !valid_ff[hand_ff] || !ref_ff[hand_ff];
   assign victim_dirty = valid_ff[hand_ff] && dirty_ff[hand_ff];
   assign flush_found  = valid_ff[scan_idx] && dirty_ff[scan_idx];
   assign dirty_live   = valid_ff & dirty_ff;
   assign others_live  = dirty_live & ~(SLOTS'(1) << scan_idx);
   assign any_emit     = cmd.emit_hit || cmd.emit_miss || cmd.emit_flush || cmd.emit_empty;

   always_comb begin
      status              = '0;
      status.hit          = tag_hit;
      status.lookup_miss  = cmp_vld_ff && !tag_hit && (cmp_idx_ff == SLOT_W'(SLOTS - 1));
      status.victim_found = victim_ok;
      status.flush_found  = flush_found;
      status.flush_last   = (others_live == '0);
      status.none_dirty   = (dirty_live == '0);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // one read port: lookup stream, victim tag, flush tag
   always_comb begin
      tag_rd_en   = 1'b0;
      tag_rd_addr = scan_idx;
      priority if (lookup_issue) begin
         tag_rd_en = 1'b1;
      end else if (cmd.sweep && victim_ok) begin
         tag_rd_en   = 1'b1;
         tag_rd_addr = hand_ff;
      end else if (cmd.flush_scan && flush_found) begin
         tag_rd_en = 1'b1;
      end
   end

   scd_ram #(
      .WIDTH (SECTOR_BITS),
      .DEPTH (SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (cmd.emit_miss),
      .wr_addr (hand_ff),
      .wr_data (sector_ff),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   always_comb begin
      valid_in   = valid_ff;
      dirty_in   = dirty_ff;
      ref_in     = ref_ff;
      hand_in    = hand_ff;
      scan_in    = scan_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      if (cmd.accept) begin
         scan_in    = '0;
         cmp_vld_in = 1'b0;
      end
      if (cmd.lookup) begin
         cmp_vld_in = lookup_issue;
         if (lookup_issue) begin
            cmp_idx_in = scan_idx;
            scan_in    = scan_ff + CNT_W'(1);
         end
      end
      if (cmd.emit_hit) begin
         ref_in[cmp_idx_ff] = 1'b1;
         if (is_write) begin
            dirty_in[cmp_idx_ff] = 1'b1;
         end
      end
      // second chance: clear the reference bit and move on
      if (cmd.sweep && !victim_ok) begin
         ref_in[hand_ff] = 1'b0;
         hand_in = (hand_ff == SLOT_W'(SLOTS - 1)) ? '0 : hand_ff + SLOT_W'(1);
      end
      if (cmd.emit_miss) begin
         valid_in[hand_ff] = 1'b1;
         ref_in[hand_ff]   = 1'b1;
         dirty_in[hand_ff] = is_write;
      end
      if (cmd.flush_scan && !flush_found) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (cmd.emit_flush) begin
         dirty_in[scan_idx] = 1'b0;
         scan_in            = scan_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_wb_in    = rsp_wb_ff;
      rsp_wbsec_in = rsp_wbsec_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      priority if (cmd.emit_hit) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b1;
         rsp_slot_in  = cmp_idx_ff;
         rsp_fill_in  = 1'b0;
         rsp_wb_in    = 1'b0;
         rsp_wbsec_in = '0;
         rsp_last_in  = 1'b1;
      end else if (cmd.emit_miss) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_slot_in  = hand_ff;
         rsp_fill_in  = 1'b1;
         rsp_wb_in    = victim_dirty;
         rsp_wbsec_in = victim_dirty ? tag_rd_data : '0;
         rsp_last_in  = 1'b1;
      end else if (cmd.emit_flush) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_slot_in  = scan_idx;
         rsp_fill_in  = 1'b0;
         rsp_wb_in    = 1'b1;
         rsp_wbsec_in = tag_rd_data;
         rsp_last_in  = (others_live == '0);
      end else if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = 1'b0;
         rsp_slot_in  = '0;
         rsp_fill_in  = 1'b0;
         rsp_wb_in    = 1'b0;
         rsp_wbsec_in = '0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         ref_ff       <= '0;
         hand_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         ref_ff       <= ref_in;
         hand_ff      <= hand_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff   <= req_func;
         sector_ff <= req_sector;
      end
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_wbsec_ff <= rsp_wbsec_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_fill_needed      = rsp_fill_ff;
   assign rsp_writeback_needed = rsp_wb_ff;
   assign rsp_writeback_sector = rsp_wbsec_ff;
   assign rsp_last             = rsp_last_ff;

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      any_emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over a beat not yet taken");

   a_hand_still: assert property (@(posedge clock) disable iff (reset)
      !cmd.sweep |=> $stable(hand_ff))
      else $error("clock hand moved outside a sweep");

   a_victim_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_miss |-> victim_ok)
      else $error("miss installed over a referenced valid slot");

   a_flush_dirty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_flush |-> flush_found)
      else $error("writeback reported for a clean slot");

endmodule

// ===== src/sector_cache_clock_directory.sv =====
// a hit in slot k answers once the lookup stream has compared slot k, a miss once all
//   SLOTS tags are compared and the clock hand has reached a victim
// throughput: one request at a time, one tag memory entry per cycle; the next request
//   is taken only after the response is loaded; response stalls hold a request back
// reset: synchronous, clears valid, dirty and reference bits, the clock hand and the
//   response valid; tag memory is left as is and read only behind a valid bit
module sector_cache_clock_directory #(
   parameter int SLOTS       = 64,
   parameter int SECTOR_BITS = 32
) (
   input logic clock,
   input logic reset,
   scd_req_if.sink   req_bus,
   scd_rsp_if.source rsp_bus
);
   import scd_pkg::*;

   // command and status between the sequencer and the directory datapath
   cmd_type    cmd;
   status_type status;

   // controller: walks lookup, sweep and flush one step per cycle, waiting while the response register is full
   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: slot state bits, clock hand, tag memory and the response register
   scd_dpath #(
      .SLOTS       (SLOTS),
      .SECTOR_BITS (SECTOR_BITS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .req_func             (req_bus.func),
      .req_sector           (req_bus.sector),
      .cmd                  (cmd),
      .status               (status),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_hit              (rsp_bus.hit),
      .rsp_slot             (rsp_bus.slot),
      .rsp_fill_needed      (rsp_bus.fill_needed),
      .rsp_writeback_needed (rsp_bus.writeback_needed),
      .rsp_writeback_sector (rsp_bus.writeback_sector),
      .rsp_last             (rsp_bus.last)
   );

endmodule
